// ----- hw/rtl/rda_pkg.sv -----
// Shared types and codes for the region directory allocator.
`default_nettype none

package rda_pkg;

  // One directory entry; the upper address is called last to keep it apart from the keyword.
  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] first;
    logic [15:0] last;
  } rda_entry_t;

  localparam int unsigned EntryWidth = 40;
  localparam int unsigned CfgWidth   = 7;
  localparam int unsigned AddrWidth  = 16;

  // Result status codes.
  localparam logic [2:0] StNew         = 3'd0;
  localparam logic [2:0] StOld         = 3'd1;
  localparam logic [2:0] StMismatch    = 3'd2;
  localparam logic [2:0] StFull        = 3'd3;
  localparam logic [2:0] StNoSpace     = 3'd4;
  localparam logic [2:0] StUnsupported = 3'd5;

endpackage

`default_nettype wire

// ----- hw/rtl/rda_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none

module rda_ram #(
  parameter int unsigned WIDTH = 40,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                     wdata_i,
  input  wire logic                                 re_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/region_directory_allocator.sv -----
// Top level of the region directory allocator: request handling, directory scan and allocation.
`default_nettype none

// The block takes one request at a time and answers each with exactly one result item. The
// directory lives in a RAM with a registered read, and the scan visits each entry in a read
// state, then an evaluate state. A request while dir_entries is zero skips the scan. No
// clearing pass is needed after reset: entries are always written in order from entry 0, so
// a fill count marks which entries hold data and the rest read as empty. The configuration
// port is always ready and should only be written while no request is in flight.
module region_directory_allocator #(
  parameter int unsigned DIR_DEPTH   = 64,
  parameter int unsigned MEM_BYTES   = 8192,
  parameter int unsigned ENTRY_BYTES = 5
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration write channel: dir_entries.
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [6:0]  cfg_data_i,
  // Request stream.
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [23:0] s_axis_tdata_i,  // request_id [7:0], request_bytes [23:8]
  // Result stream.
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic      [47:0] m_axis_tdata_o   // status [2:0], region_id [10:3],
                                            // region_start [26:11], region_end [42:27], zero pad
);

  localparam int unsigned IdxW = (DIR_DEPTH > 1) ? $clog2(DIR_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DIR_DEPTH + 1);
  localparam int unsigned CmpW = (CntW > rda_pkg::CfgWidth) ? CntW : rda_pkg::CfgWidth;

  // Sequencer states.
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_READ   = 3'd1;
  localparam logic [2:0] S_EVAL   = 3'd2;
  localparam logic [2:0] S_ALLOC  = 3'd3;
  localparam logic [2:0] S_RESULT = 3'd4;

  logic [2:0]                  state_q, state_d;
  logic [rda_pkg::CfgWidth-1:0] dir_entries_q;
  logic [CntW-1:0]             fill_q, fill_d;
  logic [CntW-1:0]             idx_q, idx_d;
  logic [CntW-1:0]             n_q, n_d;
  logic [15:0]                 free_q, free_d;
  logic [7:0]                  req_id_q, req_id_d;
  logic [15:0]                 req_bytes_q, req_bytes_d;
  logic [2:0]                  res_status_q, res_status_d;
  logic [7:0]                  res_id_q, res_id_d;
  logic [15:0]                 res_first_q, res_first_d;
  logic [15:0]                 res_last_q, res_last_d;
  logic                        out_valid_q;
  logic [42:0]                 out_data_q;

  logic                        ram_we;
  logic                        ram_re;
  rda_pkg::rda_entry_t         ram_wdata;
  logic [rda_pkg::EntryWidth-1:0] ram_rdata;
  rda_pkg::rda_entry_t         entry;
  logic [CmpW-1:0]             cfg_wide;
  logic [CntW-1:0]             n_clip;
  logic [15:0]                 entry_size;
  logic [15:0]                 new_last;
  logic                        no_space;
  logic                        in_accept;
  logic                        out_free;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_accept       = s_axis_tvalid_i & s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'd0, out_data_q};

  // Clip the register to the directory depth.
  assign cfg_wide = CmpW'(dir_entries_q);
  assign n_clip   = (cfg_wide > CmpW'(DIR_DEPTH)) ? CntW'(DIR_DEPTH) : CntW'(cfg_wide);

  // Entries at or above the fill count were never written and read as empty.
  assign entry      = (idx_q < fill_q) ? rda_pkg::rda_entry_t'(ram_rdata) : '0;
  assign entry_size = entry.last - entry.first + 16'd1;

  // Placement of a new region after the last used one.
  assign new_last = free_q + req_bytes_q - 16'd1;
  assign no_space = (new_last < free_q) || ({1'b0, new_last} >= 17'(MEM_BYTES));

  assign ram_re          = (state_q == S_READ);
  assign ram_we          = (state_q == S_ALLOC) && !no_space;
  assign ram_wdata.id    = req_id_q;
  assign ram_wdata.first = free_q;
  assign ram_wdata.last  = new_last;

  rda_ram #(
    .WIDTH (rda_pkg::EntryWidth),
    .DEPTH (DIR_DEPTH)
  ) u_dir_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q[IdxW-1:0]),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (idx_q[IdxW-1:0]),
    .rdata_o (ram_rdata)
  );

  // Scan and allocation sequencer.
  always_comb begin
    state_d      = state_q;
    fill_d       = fill_q;
    idx_d        = idx_q;
    n_d          = n_q;
    free_d       = free_q;
    req_id_d     = req_id_q;
    req_bytes_d  = req_bytes_q;
    res_status_d = res_status_q;
    res_id_d     = res_id_q;
    res_first_d  = res_first_q;
    res_last_d   = res_last_q;
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          req_id_d     = s_axis_tdata_i[7:0];
          req_bytes_d  = s_axis_tdata_i[23:8];
          n_d          = n_clip;
          idx_d        = '0;
          free_d       = 16'(32'(n_clip) * ENTRY_BYTES);
          res_status_d = rda_pkg::StUnsupported;
          res_id_d     = '0;
          res_first_d  = '0;
          res_last_d   = '0;
          state_d      = (n_clip == '0) ? S_RESULT : S_READ;
        end
      end
      S_READ: begin
        state_d = S_EVAL;
      end
      S_EVAL: begin
        if (entry.id == 8'd0) begin
          state_d = S_ALLOC;
        end else if (entry.id == req_id_q) begin
          res_status_d = (entry_size != req_bytes_q) ? rda_pkg::StMismatch : rda_pkg::StOld;
          res_id_d     = entry.id;
          res_first_d  = entry.first;
          res_last_d   = entry.last;
          state_d      = S_RESULT;
        end else begin
          free_d = entry.last + 16'd1;
          if (idx_q + CntW'(1) == n_q) begin
            res_status_d = rda_pkg::StFull;
            state_d      = S_RESULT;
          end else begin
            idx_d   = idx_q + CntW'(1);
            state_d = S_READ;
          end
        end
      end
      S_ALLOC: begin
        if (no_space) begin
          res_status_d = rda_pkg::StNoSpace;
        end else begin
          res_status_d = rda_pkg::StNew;
          res_id_d     = req_id_q;
          res_first_d  = free_q;
          res_last_d   = new_last;
          if (idx_q >= fill_q) begin
            fill_d = idx_q + CntW'(1);
          end
        end
        state_d = S_RESULT;
      end
      S_RESULT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      fill_q        <= '0;
      dir_entries_q <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      if (cfg_valid_i && cfg_ready_o) begin
        dir_entries_q <= cfg_data_i;
      end
      if ((state_q == S_RESULT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    n_q          <= n_d;
    free_q       <= free_d;
    req_id_q     <= req_id_d;
    req_bytes_q  <= req_bytes_d;
    res_status_q <= res_status_d;
    res_id_q     <= res_id_d;
    res_first_q  <= res_first_d;
    res_last_q   <= res_last_d;
    if ((state_q == S_RESULT) && out_free) begin
      out_data_q <= {res_last_q, res_first_q, res_id_q, res_status_q};
    end
  end

  // The fill count never passes the directory depth.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CntW'(DIR_DEPTH))
    else $error("fill count beyond directory depth");

  // Writes keep the written entries contiguous from entry zero.
  a_write_contig: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (idx_q <= fill_q))
    else $error("directory write leaves a gap");

  // A new result only appears after the result state.
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(state_q == S_RESULT))
    else $error("result shown without a finished request");

  // No request is taken while a scan is in progress.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EVAL || state_q == S_READ || state_q == S_ALLOC) |-> !s_axis_tready_o)
    else $error("request accepted during a scan");

endmodule

`default_nettype wire
